/* design/med1d_pkg.sv */
// Shared types and constants for the sliding-window median filter.
package med1d_pkg;

    // Default sizes, handed to the top-level parameters.
    localparam int WINDOW_MAX_DEF  = 15;
    localparam int SAMPLE_BITS_DEF = 16;

    // Window-size register and position counter.
    localparam int                  CFG_BITS        = 4;
    localparam logic [CFG_BITS-1:0] WINDOW_SIZE_RST = 4'd5;
    localparam int                  COUNT_BITS      = 16;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LOAD,
        S_SKIP,
        S_SEARCH
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic push;        // shift an accepted sample into the window store
        logic load;        // copy the store into the working taps
        logic skip_shift;  // pre-shift the taps for a short vector
        logic next_cand;   // try the next median candidate
        logic emit;        // load the output register with the candidate
        logic advance;     // move the centre one element toward the newest
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_last;     // the item in work carried the last flag
        logic count_gt_k;  // enough samples to fill the centre tap
        logic skip_zero;   // no pre-shifts left
        logic cen_zero;    // the centre is the newest sample
        logic hit;         // the current candidate has the median rank
        logic out_free;    // the output register can take a result
    } t_dp_status;

endpackage

/* design/med1d_dp.sv */
// Datapath: window store, working taps, rank counter and output register.
module med1d_dp #(
    parameter int WINDOW_MAX  = med1d_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = med1d_pkg::SAMPLE_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [med1d_pkg::CFG_BITS-1:0]     i_cfg_wdata,
    input  logic signed [SAMPLE_BITS-1:0]      i_sample,
    input  logic                               i_last,
    input  med1d_pkg::t_dp_cmd                 i_cmd,
    output med1d_pkg::t_dp_status              o_status,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic signed [SAMPLE_BITS-1:0]      o_filtered,
    output logic                               o_last_out
);

    localparam int         IW    = $clog2(WINDOW_MAX);
    localparam int         CW    = $clog2(WINDOW_MAX + 1);
    localparam int         CB    = med1d_pkg::COUNT_BITS;
    localparam logic [7:0] K_CAP = 8'((WINDOW_MAX - 1) / 2);

    logic [med1d_pkg::CFG_BITS-1:0]   r_ws;
    logic [CB-1:0]                    r_count;
    logic                             r_last;
    logic signed [SAMPLE_BITS-1:0]    r_store [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0]    r_work  [WINDOW_MAX];
    logic [WINDOW_MAX-1:0]            r_wvalid;
    logic [IW-1:0]                    r_skip;
    logic [IW-1:0]                    r_cen;
    logic [IW-1:0]                    r_cand;
    logic                             r_ovalid;
    logic signed [SAMPLE_BITS-1:0]    r_filtered;
    logic                             r_last_out;

    logic [7:0]                       half8;
    logic [7:0]                       k8;
    logic [7:0]                       two_k8;
    logic [IW-1:0]                    k;
    logic [IW-1:0]                    two_k;
    logic                             short_vec;
    logic [IW-1:0]                    skip_nxt;
    logic [IW-1:0]                    cen_nxt;
    logic signed [SAMPLE_BITS-1:0]    eff [WINDOW_MAX];
    logic signed [SAMPLE_BITS-1:0]    centre;
    logic signed [SAMPLE_BITS-1:0]    cand_val;
    logic [WINDOW_MAX-1:0]            less_vec;
    logic [WINDOW_MAX-1:0]            same_vec;
    logic [CW:0]                      less_n;
    logic [CW:0]                      same_n;
    logic [CW:0]                      k_c;
    logic                             hit;

    // Half window, capped so that the window fits the store.
    always_comb begin
        half8  = {5'b0, r_ws[3:1]};
        k8     = (half8 > K_CAP) ? K_CAP : half8;
        two_k8 = {k8[6:0], 1'b0};
        k      = k8[IW-1:0];
        two_k  = two_k8[IW-1:0];
        k_c    = k8[CW:0];
    end

    // A vector no longer than the half window starts its flush with fewer centres.
    always_comb begin
        short_vec = (r_count - CB'(1)) < {8'b0, k8};
        skip_nxt  = short_vec ? IW'(k8 - (r_count[7:0] - 8'd1)) : '0;
        cen_nxt   = short_vec ? IW'(r_count[7:0] - 8'd1) : k;
    end

    // Taps outside the vector take the centre value; rank the candidate.
    always_comb begin
        centre   = r_work[k];
        for (int j = 0; j < WINDOW_MAX; j++) begin
            eff[j] = r_wvalid[j] ? r_work[j] : centre;
        end
        cand_val = eff[r_cand];
        for (int j = 0; j < WINDOW_MAX; j++) begin
            less_vec[j] = (8'(j) <= two_k8) && (eff[j] < cand_val);
            same_vec[j] = (8'(j) <= two_k8) && (eff[j] == cand_val);
        end
        less_n = (CW + 1)'($countones(less_vec));
        same_n = (CW + 1)'($countones(same_vec));
        hit    = (less_n <= k_c) && (k_c < less_n + same_n);
    end

    // Window-size register and the position counter.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ws    <= med1d_pkg::WINDOW_SIZE_RST;
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_ws    <= i_cfg_wdata;
            r_count <= '0;
        end else if (i_cmd.push) begin
            if (r_count != '1) begin
                r_count <= r_count + CB'(1);
            end
        end else if (i_cmd.load && r_last) begin
            r_count <= '0;
        end
    end

    // Window store, newest sample at index zero.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            r_store[0] <= i_sample;
            for (int j = 1; j < WINDOW_MAX; j++) begin
                r_store[j] <= r_store[j-1];
            end
            r_last <= i_last;
        end
    end

    // Working taps: store copy, shifted one place per alignment step or centre.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            for (int j = 0; j < WINDOW_MAX; j++) begin
                r_work[j]   <= r_store[j];
                r_wvalid[j] <= CB'(j) < r_count;
            end
            r_skip <= skip_nxt;
            r_cen  <= cen_nxt;
        end else if (i_cmd.skip_shift || i_cmd.advance) begin
            r_wvalid[0] <= 1'b0;
            for (int j = 1; j < WINDOW_MAX; j++) begin
                r_work[j]   <= r_work[j-1];
                r_wvalid[j] <= r_wvalid[j-1];
            end
            if (i_cmd.skip_shift) begin
                r_skip <= r_skip - IW'(1);
            end
            if (i_cmd.advance) begin
                r_cen <= r_cen - IW'(1);
            end
        end
    end

    // Candidate index of the rank search.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cand <= '0;
        end else if (i_cmd.load || i_cmd.advance) begin
            r_cand <= '0;
        end else if (i_cmd.next_cand) begin
            r_cand <= r_cand + IW'(1);
        end
    end

    // Output register; a result waits here until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_filtered <= cand_val;
            r_last_out <= r_last && (r_cen == '0);
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_filtered  = r_filtered;
    assign o_last_out  = r_last_out;

    // Status toward the controller.
    always_comb begin
        o_status.is_last    = r_last;
        o_status.count_gt_k = r_count > {8'b0, k8};
        o_status.skip_zero  = (r_skip == '0);
        o_status.cen_zero   = (r_cen == '0);
        o_status.hit        = hit;
        o_status.out_free   = !r_ovalid || i_out_ready;
    end

`ifndef SYNTH
    // The centre tap always lies inside the vector when a median is taken.
    a_centre_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> r_wvalid[k])
        else $error("median taken with the centre tap outside the vector");

    // The rank search finds the median before it runs off the window.
    a_cand_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.next_cand |-> (r_cand < two_k))
        else $error("rank search stepped past the last tap");

    // A waiting result keeps its value until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !i_out_ready) |=> (r_ovalid && $stable(r_filtered)
                                        && $stable(r_last_out)))
        else $error("waiting result changed before its transfer");
`endif

endmodule

/* design/med1d_ctrl.sv */
// Controller: sequences loading, short-vector alignment, rank search and output.
module med1d_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  med1d_pkg::t_dp_status i_status,
    output med1d_pkg::t_dp_cmd    o_cmd
);

    med1d_pkg::t_state r_state;
    med1d_pkg::t_state n_state;

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= med1d_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            med1d_pkg::S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.push = 1'b1;
                    n_state    = med1d_pkg::S_LOAD;
                end
            end
            med1d_pkg::S_LOAD: begin
                o_cmd.load = 1'b1;
                if (i_status.is_last) begin
                    n_state = med1d_pkg::S_SKIP;
                end else if (i_status.count_gt_k) begin
                    n_state = med1d_pkg::S_SEARCH;
                end else begin
                    n_state = med1d_pkg::S_IDLE;
                end
            end
            med1d_pkg::S_SKIP: begin
                if (i_status.skip_zero) begin
                    n_state = med1d_pkg::S_SEARCH;
                end else begin
                    o_cmd.skip_shift = 1'b1;
                end
            end
            med1d_pkg::S_SEARCH: begin
                if (!i_status.hit) begin
                    o_cmd.next_cand = 1'b1;
                end else if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.is_last && !i_status.cen_zero) begin
                        o_cmd.advance = 1'b1;
                    end else begin
                        n_state = med1d_pkg::S_IDLE;
                    end
                end
            end
            default: begin
                n_state = med1d_pkg::S_IDLE;
            end
        endcase
    end

`ifndef SYNTH
    // A result is never written over one that still waits for its transfer.
    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> i_status.out_free)
        else $error("output register overwritten");

    // Every accepted sample is followed by a load of the working taps.
    a_push_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |=> o_cmd.load)
        else $error("accepted sample not loaded");

    // Alignment shifts only happen while flushing a vector.
    a_skip_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.skip_shift |-> (i_status.is_last && !i_status.skip_zero))
        else $error("alignment shift outside a flush");
`endif

endmodule

/* design/median_filter_1d.sv */
// Sliding-window median filter over a vector of signed samples.
// Input channel: i_in_valid / o_in_ready carry i_sample and i_last; i_last
// marks the final sample of a vector. Output channel: o_out_valid /
// i_out_ready carry o_filtered and o_last_out; o_last_out marks the final
// filtered element. The window size is written through i_cfg_we and
// i_cfg_wdata; the user must write it only while the block is idle, which
// the block itself does not enforce. A write also starts a new vector.
// Each output is the median of the 2k+1 taps around one element, k being
// half the window size, capped at (WINDOW_MAX-1)/2; taps outside the
// vector take the centre value. Outputs lag the input by k samples; the
// last sample flushes the rest. A sample is loaded in the cycle after its
// transfer, and the median is found by rank counting, one candidate tap
// per cycle. A flush adds alignment shifts for a short vector, then a
// search for each further result. Reset clears the window size to 5 and
// the position count to zero.
// A new sample is taken while a result waits in the output register; when
// the receiver stalls, the next result holds the search until it drains.
module median_filter_1d #(
    parameter int WINDOW_MAX  = med1d_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = med1d_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [med1d_pkg::CFG_BITS-1:0]  i_cfg_wdata,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic signed [SAMPLE_BITS-1:0]   i_sample,
    input  logic                            i_last,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic signed [SAMPLE_BITS-1:0]   o_filtered,
    output logic                            o_last_out
);

    med1d_pkg::t_dp_cmd    cmd;
    med1d_pkg::t_dp_status status;

    // Sequencer.
    med1d_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    // Window storage and median selection.
    med1d_dp #(
        .WINDOW_MAX  (WINDOW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_sample    (i_sample),
        .i_last      (i_last),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_filtered  (o_filtered),
        .o_last_out  (o_last_out)
    );

endmodule
